// ===== rtl/mrts_pkg.sv =====
// ----------------------------------------------------------------------------
// mrts_pkg - shared types and constants of the multi-rate tick scheduler
// Command codes, register indexes, field widths and the serial lane control.
// ----------------------------------------------------------------------------
`default_nettype none

package mrts_pkg;

    // field widths
    localparam int CMD_W     = 2;
    localparam int CHAN_W    = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CD_W      = 21;
    localparam int IV_W      = 20;
    localparam int SEC_W     = 17;
    localparam int PEND_W    = 8;
    localparam int MASK_W    = 8;

    // serial pass length: one bit above the widest countdown
    localparam int WORK_W = CD_W + 1;
    localparam int BIT_W  = $clog2(WORK_W);

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POLL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CPS  = 1'd1;

    // register reset values
    localparam logic [CFG_W-1:0] BASE_RESET = 16'd1680;
    localparam logic [CFG_W-1:0] CPS_RESET  = 16'd16800;

    localparam logic [PEND_W-1:0] PEND_MAX = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_lane_ctl;

endpackage

`default_nettype wire

// ===== rtl/mrts_lane.sv =====
// ----------------------------------------------------------------------------
// mrts_lane - bit-serial Bresenham step of one countdown
// Subtracts the base interval and adds the carry interval one bit per cycle while shift is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mrts_lane #(
    parameter int CNT_W = 21,
    parameter int ADD_W = 20
) (
    input  wire logic                          i_clk,
    input  wire mrts_pkg::t_lane_ctl           i_ctl,
    input  wire logic signed [CNT_W-1:0]       i_count,
    input  wire logic [mrts_pkg::CFG_W-1:0]    i_sub,
    input  wire logic [ADD_W-1:0]              i_add,
    output logic                               o_fired,
    output logic signed [CNT_W-1:0]            o_result
);
    import mrts_pkg::*;

    // lowest CNT_W-bit value, sign extended to the work width
    localparam logic signed [WORK_W-1:0] LOWEST =
        {{(WORK_W-CNT_W+1){1'b1}}, {(CNT_W-1){1'b0}}};

    logic signed [CNT_W-1:0]  r_cnt;
    logic [CFG_W-1:0]         r_sub;
    logic [ADD_W-1:0]         r_add;
    logic                     r_cy_d;
    logic                     r_cy_s;
    logic [WORK_W-1:0]        r_d;
    logic [WORK_W-1:0]        r_s;

    logic                     sub_bit;
    logic                     d_bit;
    logic                     d_cy;
    logic                     s_bit;
    logic                     s_cy;
    logic signed [WORK_W-1:0] pick;

    // d = count - sub (two's complement), s = d + add
    always_comb begin
        sub_bit = ~r_sub[0];
        d_bit   = r_cnt[0] ^ sub_bit ^ r_cy_d;
        d_cy    = (r_cnt[0] & sub_bit) | (r_cnt[0] & r_cy_d) | (sub_bit & r_cy_d);
        s_bit   = d_bit ^ r_add[0] ^ r_cy_s;
        s_cy    = (d_bit & r_add[0]) | (d_bit & r_cy_s) | (r_add[0] & r_cy_s);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cnt  <= i_count;
            r_sub  <= i_sub;
            r_add  <= i_add;
            r_cy_d <= 1'b1;
            r_cy_s <= 1'b0;
        end else if (i_ctl.shift) begin
            r_cnt  <= r_cnt >>> 1;
            r_sub  <= r_sub >> 1;
            r_add  <= r_add >> 1;
            r_cy_d <= d_cy;
            r_cy_s <= s_cy;
            r_d    <= {d_bit, r_d[WORK_W-1:1]};
            r_s    <= {s_bit, r_s[WORK_W-1:1]};
        end
    end

    // take the carried value when the countdown went negative, then clamp
    always_comb begin
        o_fired = r_d[WORK_W-1];
        pick    = o_fired ? $signed(r_s) : $signed(r_d);
        if (pick < LOWEST) begin
            o_result = LOWEST[CNT_W-1:0];
        end else begin
            o_result = pick[CNT_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/multi_rate_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// multi_rate_tick_scheduler - base-tick divider over a table of channels
// Bresenham countdown per channel plus a one-second countdown with a
// saturating count of pending seconds.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the item on i_cmd, i_channel, i_load_interval and
//   raise start; the item is taken on a clock edge where start is high and
//   busy is low. Every item gives one result on o_fire_mask, o_second_taken
//   and o_seconds_pending, shown for exactly one cycle with o_valid high.
//   The receiver cannot stall; capture the result in the o_valid cycle.
//   Poll, load and unknown commands finish at the accept edge: the result
//   appears in the next cycle and busy stays low, so these items may be
//   issued back to back.
//   A tick walks all countdowns in parallel lanes, bit-serially, over a
//   pass one bit longer than the 21-bit countdown, then a write-back
//   state that loads the result registers; busy is high through the pass
//   and the write-back, so a new tick is taken only after the last one.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 base interval, 1 counts per second) and restarts the one-second
//   countdown; write only while the block is idle.
//   Reset (synchronous, active low) disables all channels, clears the
//   pending count and restores both registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_rate_tick_scheduler #(
    parameter int NUM_CHANNELS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [mrts_pkg::CMD_W-1:0]        i_cmd,
    input  wire logic [mrts_pkg::CHAN_W-1:0]       i_channel,
    input  wire logic [mrts_pkg::IV_W-1:0]         i_load_interval,
    // result channel
    output logic                                   o_valid,
    output logic [mrts_pkg::MASK_W-1:0]            o_fire_mask,
    output logic                                   o_second_taken,
    output logic [mrts_pkg::PEND_W-1:0]            o_seconds_pending,
    // configuration port
    input  wire logic                              i_cfg_we,
    input  wire logic [mrts_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mrts_pkg::CFG_W-1:0]        i_cfg_data
);
    import mrts_pkg::*;

    // only the first eight channels show up in the fire mask
    localparam int MASK_N = (NUM_CHANNELS < MASK_W) ? NUM_CHANNELS : MASK_W;

    // control
    t_state              r_state;
    t_state              n_state;
    logic [BIT_W-1:0]    r_bit;
    t_lane_ctl           lane_ctl;
    logic                accept;
    logic                write_back;

    // configuration and table state
    logic [CFG_W-1:0]           r_base;
    logic [CFG_W-1:0]           r_cps;
    logic signed [CD_W-1:0]     r_cd [NUM_CHANNELS];
    logic [IV_W-1:0]            r_iv [NUM_CHANNELS];
    logic signed [SEC_W-1:0]    r_sec;
    logic [PEND_W-1:0]          r_pend;

    // result registers
    logic                r_out_valid;
    logic [MASK_W-1:0]   r_out_mask;
    logic                r_out_taken;
    logic [PEND_W-1:0]   r_out_pend;

    // lane results
    logic                   lane_fired [NUM_CHANNELS];
    logic signed [CD_W-1:0] lane_res   [NUM_CHANNELS];
    logic                   sec_fired;
    logic signed [SEC_W-1:0] sec_res;
    logic [MASK_W-1:0]      tick_mask;
    logic [PEND_W-1:0]      tick_pend;
    logic [SEC_W-1:0]       cfg_restart;

    // ------------------------------------------------------------------
    // Serial lanes: one per channel, one for the second countdown
    // ------------------------------------------------------------------
    for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
        mrts_lane #(
            .CNT_W (CD_W),
            .ADD_W (IV_W)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctl    (lane_ctl),
            .i_count  (r_cd[c]),
            .i_sub    (r_base),
            .i_add    (r_iv[c]),
            .o_fired  (lane_fired[c]),
            .o_result (lane_res[c])
        );
    end

    mrts_lane #(
        .CNT_W (SEC_W),
        .ADD_W (CFG_W)
    ) u_sec_lane (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_count  (r_sec),
        .i_sub    (r_base),
        .i_add    (r_cps),
        .o_fired  (sec_fired),
        .o_result (sec_res)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start && i_cmd == CMD_TICK) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                // advance once the last bit has gone through the lanes
                if (r_bit == BIT_W'(WORK_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy           = 1'b1;
        lane_ctl.load  = 1'b0;
        lane_ctl.shift = 1'b0;
        write_back     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy          = 1'b0;
                lane_ctl.load = start && i_cmd == CMD_TICK;
            end
            ST_RUN: begin
                lane_ctl.shift = 1'b1;
            end
            ST_DONE: begin
                write_back = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Tick results: fire mask of enabled channels, saturating seconds
    // ------------------------------------------------------------------
    always_comb begin
        tick_mask = '0;
        for (int c = 0; c < MASK_N; c++) begin
            tick_mask[c] = lane_fired[c] && (r_iv[c] != '0);
        end
        tick_pend = r_pend;
        if (sec_fired && r_pend != PEND_MAX) begin
            tick_pend = r_pend + PEND_W'(1);
        end
    end

    // a register write restarts the second countdown at the new rate
    always_comb begin
        cfg_restart = {1'b0, r_cps};
        if (i_cfg_idx == REG_CPS) begin
            cfg_restart = {1'b0, i_cfg_data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bit       <= '0;
            r_base      <= BASE_RESET;
            r_cps       <= CPS_RESET;
            r_sec       <= $signed({1'b0, CPS_RESET});
            r_pend      <= '0;
            r_out_valid <= 1'b0;
            r_out_mask  <= '0;
            r_out_taken <= 1'b0;
            r_out_pend  <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_cd[c] <= '0;
                r_iv[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= 1'b0;

            // bit counter runs only during the serial pass
            if (lane_ctl.shift) begin
                r_bit <= r_bit + BIT_W'(1);
            end else begin
                r_bit <= '0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BASE: r_base <= i_cfg_data;
                    REG_CPS:  r_cps  <= i_cfg_data;
                    default:  r_base <= r_base;
                endcase
                r_sec <= $signed(cfg_restart);
            end

            // poll, load and unknown commands complete at the accept edge
            if (accept && i_cmd != CMD_TICK) begin
                r_out_valid <= 1'b1;
                r_out_mask  <= '0;
                r_out_taken <= 1'b0;
                r_out_pend  <= r_pend;
                case (i_cmd)
                    CMD_POLL: begin
                        if (r_pend != '0) begin
                            r_pend      <= r_pend - PEND_W'(1);
                            r_out_taken <= 1'b1;
                            r_out_pend  <= r_pend - PEND_W'(1);
                        end
                    end
                    CMD_LOAD: begin
                        // drop loads to channels beyond the table
                        for (int c = 0; c < NUM_CHANNELS; c++) begin
                            if (int'(i_channel) == c) begin
                                r_iv[c] <= i_load_interval;
                                r_cd[c] <= $signed({1'b0, i_load_interval});
                            end
                        end
                    end
                    default: begin
                        r_out_taken <= 1'b0;
                    end
                endcase
            end

            // end of tick: hold disabled channels, store the rest
            if (write_back) begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    if (r_iv[c] != '0) begin
                        r_cd[c] <= lane_res[c];
                    end
                end
                r_sec       <= sec_res;
                r_pend      <= tick_pend;
                r_out_valid <= 1'b1;
                r_out_mask  <= tick_mask;
                r_out_taken <= 1'b0;
                r_out_pend  <= tick_pend;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_fire_mask       = r_out_mask;
    assign o_second_taken    = r_out_taken;
    assign o_seconds_pending = r_out_pend;

`ifndef SYNTHESIS
    // the write-back cycle always produces a result
    a_done_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE |=> o_valid)
        else $error("tick finished without a result");

    // a taken second always comes from a poll accepted in the cycle before
    a_taken_from_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_second_taken) |-> $past(start && !busy && i_cmd == CMD_POLL))
        else $error("second taken without a poll");

    // the pending count only drops through a poll that reports it
    a_pend_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend < $past(r_pend) |-> (o_valid && o_second_taken))
        else $error("pending seconds dropped without a poll");

    // a fire mask is never reported together with a taken second
    a_mask_vs_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fire_mask != '0) |-> !o_second_taken)
        else $error("fire mask on a poll result");
`endif

endmodule

`default_nettype wire
